/* rtl/core/ahfr_pkg.sv */
// Package for the ASCII hex frame receiver: widths, character codes,
// frame kinds and the hex digit decoder. No dependencies.
package ahfr_pkg;

	localparam int CHAR_W = 8;
	localparam int POS_W  = 9;
	localparam int KIND_W = 2;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CHAR_W-1:0] CHAR_DATA = 8'h44;  // 'D'
	localparam logic [CHAR_W-1:0] CHAR_ACK  = 8'h41;  // 'A'

	localparam logic [POS_W-1:0] POS_MAX = 9'd511;
	// data header is lead, two sequence digits, two length digits
	localparam logic [POS_W:0]   DATA_HDR_LEN = 10'd5;
	localparam logic [POS_W-1:0] ACK_LAST_POS = 9'd4;

	localparam logic [CHAR_W-1:0] MAX_PAYLOAD_RESET = 8'd64;

	// register index of the payload length limit
	localparam logic REG_MAX_PAYLOAD = 1'b0;

	localparam logic ITEM_PAYLOAD = 1'b0;
	localparam logic ITEM_VERDICT = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_DATA    = 2'd1,
		KIND_ACK     = 2'd2
	} frame_kind_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] val;
	} hex_digit_t;

	// uppercase hex only
	function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_digit_t r;
		r.bad = 1'b0;
		r.val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r.val = c[3:0];
		end else if (c inside {[8'h41:8'h46]}) begin
			r.val = 4'(c[3:0] + 4'd9);
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

/* rtl/core/ahfr_if.sv */
// Stream interfaces for the ASCII hex frame receiver: the character input
// channel and the result output channel. Depends on ahfr_pkg.
interface ahfr_in_if
	import ahfr_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] frame_char;
	logic              end_of_frame;

	modport source(output valid, frame_char, end_of_frame, input ready);
	modport sink(input valid, frame_char, end_of_frame, output ready);
endinterface

interface ahfr_out_if
	import ahfr_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic              item_kind;
	logic [CHAR_W-1:0] payload_char;
	logic [KIND_W-1:0] frame_type;
	logic              frame_ok;
	logic [CHAR_W-1:0] sequence_res;
	logic [CHAR_W-1:0] payload_length;
	logic              duplicate;
	logic              ack_needed;

	modport source(output valid, item_kind, payload_char, frame_type, frame_ok,
		sequence_res, payload_length, duplicate, ack_needed, input ready);
	modport sink(input valid, item_kind, payload_char, frame_type, frame_ok,
		sequence_res, payload_length, duplicate, ack_needed, output ready);
endinterface

/* rtl/core/ascii_hex_frame_receiver.sv */
// ASCII hex frame receiver, top level and only module.
// Depends on ahfr_pkg and the ahfr_in_if / ahfr_out_if interfaces.
//
// Usage:
//   in_ch carries one received character per word, with end_of_frame set on
//   the last character of a frame. Data frames are 'D', sequence (2 hex),
//   length L (2 hex), L payload characters, checksum (2 hex); acknowledge
//   frames are 'A', sequence (2 hex), checksum (2 hex). The checksum is the
//   XOR of all characters before it.
//   out_ch carries at most one word per input word: a payload character of
//   a well-formed data header (item_kind 0), or the frame verdict on the
//   end_of_frame character (item_kind 1). Other characters give no word.
//   The APB port holds the payload length limit at byte address 0 (reset 64).
// Timing:
//   An accepted character is latched in the input stage, then decoded against
//   the frame state and registered in the result register that drives out_ch.
//   One character per cycle is sustained while out_ch takes its words; the
//   frame state is updated once for each character.
// Reset and stall:
//   arst_n clears the frame state, the duplicate tracking and both stages.
//   While out_ch holds an untaken word, the input stage holds its character
//   and in_ch.ready drops only if that stage is also full.
module ascii_hex_frame_receiver
	import ahfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ahfr_in_if.sink               in_ch,
	ahfr_out_if.source            out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// ---------------- configuration ----------------
	logic [CHAR_W-1:0] max_payload_q;
	logic              cfg_wr;
	logic              cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == REG_MAX_PAYLOAD);
	assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;
	assign prdata  = cfg_hit ? {{(APB_DATA_W-CHAR_W){1'b0}}, max_payload_q}
		: '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_wr) begin
			max_payload_q <= pwdata[CHAR_W-1:0];
		end
	end

	// ---------------- input stage ----------------
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eof_s1;
	logic              out_free;
	logic              s1_fire;
	logic              in_fire;

	logic out_valid_q;

	// the output register can take a new word this cycle
	assign out_free     = !out_valid_q || out_ch.ready;
	assign s1_fire      = valid_s1 && out_free;
	assign in_ch.ready  = !valid_s1 || out_free;
	assign in_fire      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= in_ch.frame_char;
			eof_s1  <= in_ch.end_of_frame;
		end
	end

	// ---------------- frame state ----------------
	logic [POS_W-1:0]  pos_q;
	frame_kind_t       kind_q;
	logic [CHAR_W-1:0] seq_q;
	logic [CHAR_W-1:0] len_q;
	logic [CHAR_W-1:0] xor_q;
	logic [3:0]        hi_q;
	logic [CHAR_W-1:0] csum_q;
	logic              ferr_q;
	logic              have_last_q;
	logic [CHAR_W-1:0] last_seq_q;

	// values after this character
	frame_kind_t       kind_d;
	logic [CHAR_W-1:0] seq_d;
	logic [CHAR_W-1:0] len_d;
	logic [CHAR_W-1:0] xor_d;
	logic [3:0]        hi_d;
	logic [CHAR_W-1:0] csum_d;
	logic              ferr_d;
	logic              pass;
	hex_digit_t        hd;
	logic [CHAR_W-1:0] hex_byte;
	logic [POS_W:0]    pos_x;
	logic [POS_W:0]    pay_end;
	logic [POS_W:0]    last_pos;
	logic              frame_good;
	logic              dup;
	logic [POS_W-1:0]  pos_next;

	assign pos_x = {1'b0, pos_q};
	assign hd    = hex_decode(char_s1);

	always_comb begin
		// a frame opens at position zero with cleared fields
		if (pos_q == '0) begin
			if (char_s1 == CHAR_DATA) begin
				kind_d = KIND_DATA;
			end else if (char_s1 == CHAR_ACK) begin
				kind_d = KIND_ACK;
			end else begin
				kind_d = KIND_UNKNOWN;
			end
			seq_d  = '0;
			len_d  = '0;
			xor_d  = '0;
			hi_d   = '0;
			csum_d = '0;
			ferr_d = 1'b0;
		end else begin
			kind_d = kind_q;
			seq_d  = seq_q;
			len_d  = len_q;
			xor_d  = xor_q;
			hi_d   = hi_q;
			csum_d = csum_q;
			ferr_d = ferr_q;
		end
		hex_byte = {hi_d, hd.val};
		pay_end  = DATA_HDR_LEN + {2'b00, len_d};
		pass     = 1'b0;

		case (kind_d)
			KIND_DATA: begin
				if (pos_x < DATA_HDR_LEN) begin
					xor_d = xor_d ^ char_s1;
					if (pos_q != '0) begin
						if (hd.bad) begin
							ferr_d = 1'b1;
						end else if (pos_q[0]) begin
							hi_d = hd.val;
						end else if (pos_q[2:0] == 3'd2) begin
							seq_d = hex_byte;
						end else begin
							len_d = hex_byte;
							if (hex_byte > max_payload_q) begin
								ferr_d = 1'b1;
							end
						end
					end
				end else if (pos_x < pay_end) begin
					xor_d = xor_d ^ char_s1;
					pass  = !ferr_d;
				end else if (pos_x == pay_end) begin
					if (hd.bad) begin
						ferr_d = 1'b1;
					end else begin
						hi_d = hd.val;
					end
				end else if (pos_x == pay_end + 10'd1) begin
					if (hd.bad) begin
						ferr_d = 1'b1;
					end else begin
						csum_d = hex_byte;
					end
				end else begin
					ferr_d = 1'b1;
				end
			end
			KIND_ACK: begin
				if (pos_q < 9'd3) begin
					xor_d = xor_d ^ char_s1;
					if (pos_q != '0) begin
						if (hd.bad) begin
							ferr_d = 1'b1;
						end else if (pos_q[0]) begin
							hi_d = hd.val;
						end else begin
							seq_d = hex_byte;
						end
					end
				end else if (pos_q <= ACK_LAST_POS) begin
					if (hd.bad) begin
						ferr_d = 1'b1;
					end else if (pos_q[0]) begin
						hi_d = hd.val;
					end else begin
						csum_d = hex_byte;
					end
				end else begin
					ferr_d = 1'b1;
				end
			end
			default: begin
				// unknown lead: ignore characters until end of frame
			end
		endcase

		// verdict terms use the length after this character
		last_pos   = (kind_d == KIND_DATA) ? DATA_HDR_LEN + 10'd1 + {2'b00, len_d}
			: {1'b0, ACK_LAST_POS};
		frame_good = (kind_d != KIND_UNKNOWN) && !ferr_d && (pos_x == last_pos)
			&& (csum_d == xor_d);
		dup        = have_last_q && (seq_d == last_seq_q);
		pos_next   = (pos_q < POS_MAX) ? pos_q + 9'd1 : POS_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			kind_q      <= KIND_UNKNOWN;
			seq_q       <= '0;
			len_q       <= '0;
			xor_q       <= '0;
			hi_q        <= '0;
			csum_q      <= '0;
			ferr_q      <= 1'b0;
			have_last_q <= 1'b0;
			last_seq_q  <= '0;
		end else if (s1_fire) begin
			if (eof_s1) begin
				// close the frame and clear for the next one
				pos_q  <= '0;
				kind_q <= KIND_UNKNOWN;
				seq_q  <= '0;
				len_q  <= '0;
				xor_q  <= '0;
				hi_q   <= '0;
				csum_q <= '0;
				ferr_q <= 1'b0;
				if (frame_good && kind_d == KIND_DATA && !dup) begin
					have_last_q <= 1'b1;
					last_seq_q  <= seq_d;
				end
			end else begin
				pos_q  <= pos_next;
				kind_q <= kind_d;
				seq_q  <= seq_d;
				len_q  <= len_d;
				xor_q  <= xor_d;
				hi_q   <= hi_d;
				csum_q <= csum_d;
				ferr_q <= ferr_d;
			end
		end
	end

	// ---------------- result register ----------------
	logic              kind_out_q;
	logic [CHAR_W-1:0] pchar_q;
	logic [KIND_W-1:0] ftype_q;
	logic              ok_q;
	logic [CHAR_W-1:0] seq_out_q;
	logic [CHAR_W-1:0] len_out_q;
	logic              dup_q;
	logic              ack_q;
	logic              is_data_ok;

	assign is_data_ok = frame_good && (kind_d == KIND_DATA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire && (eof_s1 || pass);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			if (eof_s1) begin
				kind_out_q <= ITEM_VERDICT;
				pchar_q    <= '0;
				ftype_q    <= kind_d;
				ok_q       <= frame_good;
				seq_out_q  <= frame_good ? seq_d : '0;
				len_out_q  <= is_data_ok ? len_d : '0;
				dup_q      <= is_data_ok && dup;
				ack_q      <= is_data_ok;
			end else begin
				kind_out_q <= ITEM_PAYLOAD;
				pchar_q    <= char_s1;
				ftype_q    <= KIND_UNKNOWN;
				ok_q       <= 1'b0;
				seq_out_q  <= '0;
				len_out_q  <= '0;
				dup_q      <= 1'b0;
				ack_q      <= 1'b0;
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.item_kind      = kind_out_q;
	assign out_ch.payload_char   = pchar_q;
	assign out_ch.frame_type     = ftype_q;
	assign out_ch.frame_ok       = ok_q;
	assign out_ch.sequence_res   = seq_out_q;
	assign out_ch.payload_length = len_out_q;
	assign out_ch.duplicate      = dup_q;
	assign out_ch.ack_needed     = ack_q;

	// ---------------- assertions ----------------
	a_pos_cleared_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && eof_s1) |=> (pos_q == '0))
		else $error("frame position not cleared after verdict");

	a_ok_needs_known_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ok_q) |-> (kind_out_q == ITEM_VERDICT && ftype_q != KIND_UNKNOWN))
		else $error("valid verdict without a known frame type");

	a_ack_only_for_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ack_q) |-> (ok_q && ftype_q == KIND_DATA))
		else $error("acknowledge flagged for a frame that is not a valid data frame");

endmodule
